>>> hdl/dq_pkg.sv
package dq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_FIND       = 3'd6,
    OP_REMOVE     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
  } result_t;

endpackage

>>> hdl/dq_ram.sv
module dq_ram import dq_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/dq_seq.sv
module dq_seq import dq_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEFAULT,
  parameter int IDX_W  = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] key_mask,
  input  logic              out_free,
  output logic              res_valid,
  output result_t           res,
  output logic [CNT_W-1:0]  entry_count,
  output logic              mem_we,
  output logic [IDX_W-1:0]  mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [IDX_W-1:0]  mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  // Ring position of an offset from the front; the sum stays below twice the depth.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t            state, state_next;
  op_t               op_q, op_q_next;
  logic [DATA_W-1:0] key_q, key_q_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  pend_idx, pend_idx_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  status_t           res_status, res_status_next;

  logic hit;
  logic issue;

  assign hit   = pend && (((mem_rdata ^ key_q) & key_mask) == '0);
  assign issue = rd_idx < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    key_q      <= key_q_next;
    rd_idx     <= rd_idx_next;
    pend_idx   <= pend_idx_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    key_q_next      = key_q;
    front_next      = front;
    count_next      = count;
    rd_idx_next     = rd_idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    res_data_next   = res_data;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = front;
    mem_wdata       = key_q;
    mem_re          = 1'b0;
    mem_raddr       = front;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_q_next  = op_t'(opcode);
          key_q_next = value;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_data_next   = '0;
        res_status_next = STAT_OK;
        state_next      = ST_DONE;
        case (op_q)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (count == FULL_CNT) begin
              res_status_next = STAT_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + 1'b1;
              if (op_q == OP_PUSH_FRONT) begin
                mem_waddr  = (front == '0) ? LAST_IDX : front - 1'b1;
                front_next = mem_waddr;
              end else begin
                mem_waddr = ring_pos(front, count);
              end
            end
          end
          OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
            end else begin
              mem_re     = 1'b1;
              state_next = ST_READ;
              if (op_q == OP_POP_BACK || op_q == OP_PEEK_BACK) begin
                mem_raddr = ring_pos(front, count - 1'b1);
              end
            end
          end
          default: begin
            if (count == '0) begin
              res_status_next = STAT_NOMATCH;
            end else begin
              rd_idx_next = '0;
              pend_next   = 1'b0;
              state_next  = ST_SCAN;
            end
          end
        endcase
      end

      ST_READ: begin
        res_data_next = mem_rdata;
        state_next    = ST_DONE;
        if (op_q == OP_POP_FRONT) begin
          front_next = ring_pos(front, CNT_W'(1));
          count_next = count - 1'b1;
        end else if (op_q == OP_POP_BACK) begin
          count_next = count - 1'b1;
        end
      end

      ST_SCAN: begin
        // One read is issued per cycle while the previous one is compared.
        mem_re        = issue;
        mem_raddr     = ring_pos(front, rd_idx);
        pend_next     = issue;
        pend_idx_next = rd_idx;
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (hit) begin
          res_data_next = mem_rdata;
          state_next    = (op_q == OP_FIND) ? ST_DONE : ST_SHIFT;
        end else if (pend && pend_idx == count - 1'b1) begin
          res_status_next = STAT_NOMATCH;
          state_next      = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // Each entry behind the removed one moves one place toward the front.
        mem_re        = issue;
        mem_raddr     = ring_pos(front, rd_idx);
        mem_we        = pend;
        mem_waddr     = ring_pos(front, pend_idx - 1'b1);
        mem_wdata     = mem_rdata;
        pend_next     = issue;
        pend_idx_next = rd_idx;
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready    = (state == ST_IDLE);
  assign res_valid   = (state == ST_DONE);
  assign res.data    = res_data;
  assign res.status  = res_status;
  assign entry_count = count;

endmodule

>>> hdl/bounded_deque_with_search.sv
// Bounded double-ended queue of 32-bit words with a masked search.
// An operation enters as one transaction on the input channel (in_valid,
// in_ready, opcode, value) and produces exactly one transaction on the output
// channel (out_valid, out_ready, data, status, entry_count). The compare mask
// for find and remove is written through its own channel (cfg_valid,
// cfg_ready, cfg_data), which is always ready.
//
// Operations run one at a time through a sequencer around a single ring
// memory with a registered read port. A push or any rejected operation
// goes from the execute state straight to done, a pop or peek passes
// through a read state, and a find or remove through a scan state that
// reads one entry per cycle; a removal then shifts every later entry one
// place toward the front through the same memory port, one entry per cycle.
// The next operation is accepted the cycle after the result is handed to the
// output register, so a result waiting there does not block new work.
//
// Reset clears the front pointer, the entry count and the output valid, and
// sets the mask to all ones. Memory contents are not cleared. If the receiver
// stalls, the result holds in the output register and one more finished
// operation waits inside the sequencer until the register frees up.
module bounded_deque_with_search import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] data,
  output status_t           status,
  output logic [CNT_W-1:0]  entry_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_W-1:0] key_mask;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  logic [CNT_W-1:0]  res_count;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // The mask register is written whenever a configuration transaction arrives.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask <= '1;
    end else if (cfg_valid) begin
      key_mask <= cfg_data;
    end
  end

  // Output register: it is free when empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      data        <= res.data;
      status      <= res.status;
      entry_count <= res_count;
    end
  end

  dq_seq #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .value       (value),
    .key_mask    (key_mask),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .entry_count (res_count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  dq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> hdl/dq_checker.sv
module dq_checker import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] data,
  input status_t           status,
  input logic [CNT_W-1:0]  entry_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // No result may be offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= FULL_CNT)
    else $error("entry count above depth");

  // A dropped push means the queue was full; an empty pop means it was empty.
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != STAT_FULL || entry_count == FULL_CNT) &&
                  (status != STAT_EMPTY || entry_count == '0))
    else $error("status disagrees with entry count");

  a_fail_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> data == '0)
    else $error("failed operation returned nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status) &&
                                $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind bounded_deque_with_search dq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .data        (data),
  .status      (status),
  .entry_count (entry_count)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import dq_pkg::*;

  localparam int CNT_W     = $clog2(DEPTH_DEFAULT + 1);
  // Receiver hold-off used once to back the block up into its input channel.
  localparam int LONG_HOLD = 300;

  // One expected result of a deque operation.
  typedef struct {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } deque_reply_t;

  // Tracks the deque contents as the block should hold them and keeps the
  // results still owed by the block, oldest first.
  class deque_scoreboard;
    logic [DATA_W-1:0] store [DEPTH_DEFAULT];
    int                front;
    int                count;
    logic [DATA_W-1:0] key_mask;
    deque_reply_t      replies_due [$];
    int                mismatches;

    function new();
      front      = 0;
      count      = 0;
      key_mask   = '1;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Apply one accepted operation to the tracked deque and queue its result.
    function void note_op(op_t op, logic [DATA_W-1:0] v);
      deque_reply_t r;
      int           hit;
      r.data   = '0;
      r.status = STAT_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count == DEPTH_DEFAULT) begin
            r.status = STAT_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            front        = (front + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
            store[front] = v;
            count++;
          end else begin
            store[(front + count) % DEPTH_DEFAULT] = v;
            count++;
          end
        end
        OP_FIND, OP_REMOVE: begin
          hit = -1;
          for (int i = 0; i < count && hit < 0; i++)
            if (((store[(front + i) % DEPTH_DEFAULT] ^ v) & key_mask) == '0) hit = i;
          if (hit < 0) begin
            r.status = STAT_NOMATCH;
          end else begin
            r.data = store[(front + hit) % DEPTH_DEFAULT];
            if (op == OP_REMOVE) begin
              for (int i = hit; i + 1 < count; i++)
                store[(front + i) % DEPTH_DEFAULT] = store[(front + i + 1) % DEPTH_DEFAULT];
              count--;
            end
          end
        end
        default: begin
          if (count == 0) begin
            r.status = STAT_EMPTY;
          end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
            r.data = store[front];
            if (op == OP_POP_FRONT) begin
              front = (front + 1) % DEPTH_DEFAULT;
              count--;
            end
          end else begin
            r.data = store[(front + count - 1) % DEPTH_DEFAULT];
            if (op == OP_POP_BACK) count--;
          end
        end
      endcase
      r.count = CNT_W'(count);
      replies_due.push_back(r);
    endfunction

    task check_reply(logic [DATA_W-1:0] d, status_t s, logic [CNT_W-1:0] n);
      deque_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected result: data %h status %0d count %0d", d, s, n));
        return;
      end
      want = replies_due.pop_front();
      if (d !== want.data)
        report($sformatf("data %h, expected %h", d, want.data));
      if (s !== want.status)
        report($sformatf("status %0d, expected %0d", s, want.status));
      if (n !== want.count)
        report($sformatf("entry_count %0d, expected %0d", n, want.count));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        opcode;
  logic [DATA_W-1:0] value;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] data;
  status_t           status;
  logic [CNT_W-1:0]  entry_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data;

  deque_scoreboard sb;

  // Pacing controls for the sender and the receiver. When a side is
  // "fast" it never idles, which gives back-to-back stretches; otherwise it
  // draws a fresh random wait for every transaction.
  bit tx_fast   = 1'b0;
  bit rx_fast   = 1'b0;
  // Set by the stimulus to make the receiver take one long stall of LONG_HOLD.
  bit hold_req  = 1'b0;

  always #6 clk = ~clk;

  bounded_deque_with_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data        (data),
    .status      (status),
    .entry_count (entry_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Offer one operation and return at the edge where it is accepted. Valid
  // is only dropped when an idle gap is drawn, so a back-to-back item never
  // sees valid lowered and raised within one time step.
  task automatic send_op(op_t op, logic [DATA_W-1:0] v);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op, v);
  endtask

  // Stop offering work and wait until every owed result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // Write the compare mask; only called while the block is idle.
  task automatic write_mask(logic [DATA_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sb.key_mask  = m;
  endtask

  // Result receiver. Every result transaction is checked against the oldest
  // expectation at the edge where it is taken.
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_reply(data, status, entry_count);
    end
  end

  initial begin : stimulus
    op_t               op;
    logic [DATA_W-1:0] v;
    int                pick;
    int                push_pct;
    logic [DATA_W-1:0] phase_masks [8];
    phase_masks = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_00FF,
                    32'hFFFF_0000, 32'h8000_0001, 32'h0F0F_F0F0,
                    32'h7FFF_FFFE, 32'hFFFF_FFFF};
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = '0;
    value     = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run under the reset mask of all ones. Every read-style
    // operation first hits an empty deque, including find and remove.
    send_op(OP_POP_FRONT,  $urandom);
    send_op(OP_POP_BACK,   $urandom);
    send_op(OP_PEEK_FRONT, $urandom);
    send_op(OP_PEEK_BACK,  $urandom);
    send_op(OP_FIND,       32'h0000_0000);
    send_op(OP_REMOVE,     32'hFFFF_FFFF);
    // Build front to back: 5A5A5A5A, FFFFFFFF, 00000000, A5A5A5A5.
    send_op(OP_PUSH_BACK,  32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_BACK,  32'hA5A5_A5A5);
    send_op(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    send_op(OP_PEEK_FRONT, $urandom);
    send_op(OP_PEEK_BACK,  $urandom);
    send_op(OP_FIND,       32'hA5A5_A5A5);
    send_op(OP_FIND,       32'h1234_5678);
    send_op(OP_REMOVE,     32'h1234_5678);
    // Removing from the middle forces the later entries to shift forward.
    send_op(OP_REMOVE,     32'hFFFF_FFFF);
    send_op(OP_FIND,       32'h0000_0000);
    send_op(OP_POP_BACK,   $urandom);
    send_op(OP_POP_FRONT,  $urandom);
    send_op(OP_POP_FRONT,  $urandom);
    send_op(OP_PEEK_BACK,  $urandom);

    // Random phases. Each one starts from an idle block with a new mask and
    // its own mix: push-heavy phases run the deque into the full case, while
    // search-heavy phases drain it through removes and pops.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_mask(phase_masks[ph] ^ ((ph == 5) ? $urandom : 32'h0));
      tx_fast  = (ph % 3 == 1);
      rx_fast  = (ph % 4 == 2);
      push_pct = (ph % 3 == 0) ? 65 : ((ph % 3 == 1) ? 45 : 20);
      // In the second phase the receiver stalls for a long stretch while the
      // sender keeps offering, so the block fills up and holds off its input.
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
          op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (pick < push_pct + 25)
          op = op_t'($urandom_range(2, 5));
        else
          op = ($urandom_range(0, 1) != 0) ? OP_REMOVE : OP_FIND;
        // Most search keys are taken from a held entry, with the bits outside
        // the mask scrambled, so that matches are common; the rest miss or
        // hit by chance. Narrow values give duplicates for first-match order.
        if ((op == OP_FIND || op == OP_REMOVE) && sb.count > 0
            && $urandom_range(0, 9) < 7) begin
          v = sb.store[(sb.front + $urandom_range(0, sb.count - 1)) % DEPTH_DEFAULT];
          v = v ^ ($urandom & ~sb.key_mask);
        end else if ($urandom_range(0, 2) == 0) begin
          v = $urandom & 32'h8000_0003;
        end else begin
          v = $urandom;
        end
        send_op(op, v);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
